### sv/stfvc_pkg.sv
// ----------------------------------------------------------------------------
// stfvc_pkg: shared definitions for the surface tracing controller
// Field widths, internal datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package stfvc_pkg;

	localparam int AXES       = 3;
	localparam int COMP_W     = 20;
	localparam int VEC_W      = AXES * COMP_W;
	localparam int CMD_W      = 24;
	localparam int SP_W       = 20;
	localparam int GAIN_W     = 24;
	localparam int INTEG_W    = 48;
	localparam int VEL_W      = 32;
	localparam int E_W        = 33;
	localparam int W_W        = 37;
	localparam int ACC_W      = 54;
	localparam int MUL_A_W    = 40;
	localparam int MUL_B_W    = GAIN_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST = 24'd16777;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORCE_SETPOINT = 3'd0,
		CFG_PROP_GAIN      = 3'd1,
		CFG_INTEG_GAIN     = 3'd2,
		CFG_TRAJ_GAIN      = 3'd3,
		CFG_SAMPLE_PERIOD  = 3'd4
	} cfg_reg_t;

endpackage

### sv/stfvc_in_if.sv
// ----------------------------------------------------------------------------
// stfvc_in_if: control step channel
// Valid/ready channel carrying one control step word.
// ----------------------------------------------------------------------------
interface stfvc_in_if import stfvc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [VEC_W-1:0] normal_vec;
	logic [VEC_W-1:0] force_vec;
	logic [VEC_W-1:0] position;
	logic [VEC_W-1:0] target_position;
	logic [VEC_W-1:0] target_velocity;

	modport source (
		output valid, func, normal_vec, force_vec, position, target_position,
		target_velocity,
		input  ready
	);

	modport sink (
		input  valid, func, normal_vec, force_vec, position, target_position,
		target_velocity,
		output ready
	);
endinterface

### sv/stfvc_out_if.sv
// ----------------------------------------------------------------------------
// stfvc_out_if: commanded velocity channel
// Valid/ready channel carrying one commanded velocity word.
// ----------------------------------------------------------------------------
interface stfvc_out_if import stfvc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] cmd_x;
	logic signed [CMD_W-1:0] cmd_y;
	logic signed [CMD_W-1:0] cmd_z;
	logic                    clipped;

	modport source (
		output valid, cmd_x, cmd_y, cmd_z, clipped,
		input  ready
	);

	modport sink (
		input  valid, cmd_x, cmd_y, cmd_z, clipped,
		output ready
	);
endinterface

### sv/stfvc_mul.sv
// ----------------------------------------------------------------------------
// stfvc_mul: shared signed multiplier
// Registered signed product, one new operand pair per cycle.
// ----------------------------------------------------------------------------
module stfvc_mul import stfvc_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

### sv/surface_tracing_force_velocity_control.sv
// ----------------------------------------------------------------------------
// surface_tracing_force_velocity_control: hybrid force/velocity PI controller
// Normal force PI loop plus tangential trajectory tracking on one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one control step word (func, normal, force, positions, velocity).
//   result : one commanded velocity word per item, with a saturation flag.
//   cfg_*  : register writes, which the user must make only while the block is idle; the block does not enforce it.
// Sequencing:
//   A control step is accepted only from idle, so one step is in work at a time;
//   its fifteen products go one per cycle through a single 40x25 signed
//   multiplier with a registered output, sequenced by the state machine.
//   A clear word skips the products and returns an all-zero result.
// Reset:
//   Gains and setpoint clear, sample period returns to its default, the
//   force error integral clears and no result is pending.
// Stall:
//   A finished result waits in the output register; a new word is accepted
//   meanwhile, and its own result holds in the last step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module surface_tracing_force_velocity_control import stfvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	stfvc_in_if.sink              item,
	stfvc_out_if.source           result
);

	typedef enum logic [4:0] {
		S_IDLE, S_FN0, S_FN1, S_FN2, S_ERR, S_VEL0, S_INTEG, S_VEL1, S_PROP,
		S_VEL2, S_VF, S_NV1, S_NV2, S_W, S_NW0, S_CMD0, S_CMD1, S_CMD2, S_DONE
	} state_t;

	function automatic logic signed [INTEG_W-1:0] sat_integ(
		input logic signed [INTEG_W:0] x);
		if (x[INTEG_W:INTEG_W-1] != {2{x[INTEG_W]}})
			return x[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		return x[INTEG_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(
		input logic signed [VEL_W+17:0] x);
		if (x[VEL_W+17:VEL_W-1] != {19{x[VEL_W+17]}})
			return x[VEL_W+17] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
		return x[VEL_W-1:0];
	endfunction

	function automatic logic signed [CMD_W-1:0] sat_cmd(
		input logic signed [CMD_W+15:0] x);
		if (x[CMD_W+15:CMD_W-1] != {17{x[CMD_W+15]}})
			return x[CMD_W+15] ? {1'b1, {(CMD_W-1){1'b0}}} : {1'b0, {(CMD_W-1){1'b1}}};
		return x[CMD_W-1:0];
	endfunction

	state_t state_q;

	logic signed [SP_W-1:0]   setpoint_q;
	logic        [GAIN_W-1:0] kp_q;
	logic        [GAIN_W-1:0] ki_q;
	logic        [GAIN_W-1:0] kt_q;
	logic        [GAIN_W-1:0] period_q;
	logic signed [INTEG_W-1:0] integ_q;

	logic                    out_valid_q;
	logic signed [CMD_W-1:0] out_x_q;
	logic signed [CMD_W-1:0] out_y_q;
	logic signed [CMD_W-1:0] out_z_q;
	logic                    out_clip_q;

	logic signed [COMP_W-1:0] n_q  [AXES];
	logic signed [COMP_W-1:0] f_q  [AXES];
	logic signed [COMP_W-1:0] tv_q [AXES];
	logic signed [COMP_W:0]   dp_q [AXES];
	logic signed [VEL_W-1:0]  v_q  [AXES];
	logic signed [CMD_W-1:0]  cmd_q[AXES];
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [E_W-1:0]    e_q;
	logic signed [VEL_W-1:0]  vf_q;
	logic signed [W_W-1:0]    w_q;
	logic                     clip_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_s1;

	logic                      accept;
	logic [1:0]                ax;
	logic signed [ACC_W-1:0]   prod_lo;
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [ACC_W-1:0]   err_diff;
	logic signed [VEL_W+17:0]  vel_raw;
	logic signed [VEL_W-1:0]   vel_sat;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_sat;
	logic signed [VEL_W+17:0]  vf_sum;
	logic signed [VEL_W-1:0]   vf_sat;
	logic signed [W_W-1:0]     w_next;
	logic signed [CMD_W+15:0]  cmd_sum;
	logic signed [CMD_W-1:0]   cmd_sat;

	stfvc_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	assign accept       = item.valid && (state_q == S_IDLE);
	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.cmd_x = out_x_q;
	assign result.cmd_y = out_y_q;
	assign result.cmd_z = out_z_q;
	assign result.clipped = out_clip_q;

	always_comb begin
		case (state_q)
			S_VEL1, S_CMD1: ax = 2'd1;
			S_VEL2, S_CMD2: ax = 2'd2;
			default:        ax = 2'd0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FN0: begin
				mul_a = MUL_A_W'(f_q[0]);
				mul_b = MUL_B_W'(n_q[0]);
			end
			S_FN1: begin
				mul_a = MUL_A_W'(f_q[1]);
				mul_b = MUL_B_W'(n_q[1]);
			end
			S_FN2: begin
				mul_a = MUL_A_W'(f_q[2]);
				mul_b = MUL_B_W'(n_q[2]);
			end
			S_ERR: begin
				mul_a = MUL_A_W'(dp_q[0]);
				mul_b = $signed({1'b0, kt_q});
			end
			S_VEL0: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = $signed({1'b0, period_q});
			end
			S_INTEG: begin
				mul_a = MUL_A_W'(dp_q[1]);
				mul_b = $signed({1'b0, kt_q});
			end
			S_VEL1: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = $signed({1'b0, kp_q});
			end
			S_PROP: begin
				mul_a = MUL_A_W'(dp_q[2]);
				mul_b = $signed({1'b0, kt_q});
			end
			S_VEL2: begin
				mul_a = $signed(integ_q[INTEG_W-1:8]);
				mul_b = $signed({1'b0, ki_q});
			end
			S_VF: begin
				mul_a = MUL_A_W'(v_q[0]);
				mul_b = MUL_B_W'(n_q[0]);
			end
			S_NV1: begin
				mul_a = MUL_A_W'(v_q[1]);
				mul_b = MUL_B_W'(n_q[1]);
			end
			S_NV2: begin
				mul_a = MUL_A_W'(v_q[2]);
				mul_b = MUL_B_W'(n_q[2]);
			end
			S_NW0: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'(n_q[0]);
			end
			S_CMD0: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'(n_q[1]);
			end
			S_CMD1: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'(n_q[2]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		prod_lo   = $signed(prod_s1[ACC_W-1:0]);
		acc_sum   = acc_q + prod_lo;
		err_diff  = acc_sum - $signed({{(ACC_W-SP_W-18){setpoint_q[SP_W-1]}}, setpoint_q, 18'b0});
		vel_raw   = (VEL_W+18)'(tv_q[ax]) - (VEL_W+18)'($signed(prod_s1[45:16]));
		vel_sat   = sat_vel(vel_raw);
		integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'($signed(prod_s1[57:16]));
		integ_sat = sat_integ(integ_sum);
		vf_sum    = (VEL_W+18)'(acc_q) + (VEL_W+18)'($signed(prod_s1[PROD_W-1:16]));
		vf_sat    = sat_vel(vf_sum);
		w_next    = W_W'(vf_q) - W_W'($signed(acc_sum[ACC_W-1:18]));
		cmd_sum   = (CMD_W+16)'(v_q[ax]) + (CMD_W+16)'($signed(prod_s1[56:18]));
		cmd_sat   = sat_cmd(cmd_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			setpoint_q  <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			kt_q        <= '0;
			period_q    <= SAMPLE_PERIOD_RST;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_z_q     <= '0;
			out_clip_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_FORCE_SETPOINT: setpoint_q <= $signed(cfg_data[SP_W-1:0]);
					CFG_PROP_GAIN:      kp_q       <= cfg_data;
					CFG_INTEG_GAIN:     ki_q       <= cfg_data;
					CFG_TRAJ_GAIN:      kt_q       <= cfg_data;
					CFG_SAMPLE_PERIOD:  period_q   <= cfg_data;
					default: ;
				endcase
			end
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						if (item.func) begin
							integ_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_FN0;
						end
					end
				end
				S_INTEG: begin
					integ_q <= integ_sat;
					state_q <= S_VEL1;
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= cmd_q[0];
						out_y_q     <= cmd_q[1];
						out_z_q     <= cmd_q[2];
						out_clip_q  <= clip_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= state_t'(state_q + 5'd1);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < AXES; k++) begin
				n_q[k]   <= $signed(item.normal_vec[k*COMP_W +: COMP_W]);
				f_q[k]   <= $signed(item.force_vec[k*COMP_W +: COMP_W]);
				tv_q[k]  <= $signed(item.target_velocity[k*COMP_W +: COMP_W]);
				dp_q[k]  <= $signed({item.position[k*COMP_W+COMP_W-1],
					item.position[k*COMP_W +: COMP_W]})
					- $signed({item.target_position[k*COMP_W+COMP_W-1],
					item.target_position[k*COMP_W +: COMP_W]});
				cmd_q[k] <= '0;
			end
			clip_q <= 1'b0;
		end
		case (state_q)
			S_FN1, S_NV1: acc_q <= prod_lo;
			S_FN2, S_NV2: acc_q <= acc_sum;
			S_ERR:        e_q   <= err_diff[E_W+9:10];
			S_VEL0, S_VEL1, S_VEL2: begin
				v_q[ax] <= vel_sat;
				clip_q  <= clip_q | ((VEL_W+18)'(vel_sat) != vel_raw);
			end
			S_INTEG: clip_q <= clip_q | ((INTEG_W+1)'(integ_sat) != integ_sum);
			S_PROP:  acc_q  <= ACC_W'($signed(prod_s1[57:16]));
			S_VF: begin
				vf_q   <= vf_sat;
				clip_q <= clip_q | ((VEL_W+18)'(vf_sat) != vf_sum);
			end
			S_W: w_q <= w_next;
			S_CMD0, S_CMD1, S_CMD2: begin
				cmd_q[ax] <= cmd_sat;
				clip_q    <= clip_q | ((CMD_W+16)'(cmd_sat) != cmd_sum);
			end
			default: ;
		endcase
	end

endmodule

### sv/stfvc_chk.sv
// ----------------------------------------------------------------------------
// stfvc_chk: port checker for the surface tracing controller
// Watches the channel ports and flags ordering and result errors.
// ----------------------------------------------------------------------------
module stfvc_chk import stfvc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_ready,
	input logic                    item_func,
	input logic                    result_valid,
	input logic                    result_ready,
	input logic signed [CMD_W-1:0] cmd_x,
	input logic signed [CMD_W-1:0] cmd_y,
	input logic signed [CMD_W-1:0] cmd_z,
	input logic                    clipped
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(cmd_x)
			&& $stable(cmd_y) && $stable(cmd_z) && $stable(clipped))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input ready right after an accepted word");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func && !result_valid |-> ##2
			result_valid && cmd_x == 0 && cmd_y == 0 && cmd_z == 0 && !clipped)
		else $error("clear word did not return a zero result");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared while the block was idle");

endmodule

bind surface_tracing_force_velocity_control stfvc_chk u_stfvc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_func    (item.func),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.cmd_x        (result.cmd_x),
	.cmd_y        (result.cmd_y),
	.cmd_z        (result.cmd_z),
	.clipped      (result.clipped)
);

### verif/surface_tracing_force_velocity_control_test.sv
// ----------------------------------------------------------------------------
// surface_tracing_force_velocity_control_test: control step regression
// Drives control step words through the valid/ready channel in bursts while
// the command channel stalls on its own pattern, and predicts each command
// word with a fixed point model of the PI force loop and tangential tracking
// or takes it from the directed table. That table of extremes and special
// cases is followed by random phases under several register settings, one
// of which winds the force error integral into saturation.
// ----------------------------------------------------------------------------
module surface_tracing_force_velocity_control_test;
	import stfvc_pkg::*;

	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [COMP_W-1:0] CMAX = 20'h7FFFF;
	localparam logic [COMP_W-1:0] CMIN = 20'h80000;
	localparam logic [COMP_W-1:0] UNIT = 20'h40000;
	localparam logic [COMP_W-1:0] DIAG = 20'd185364;
	localparam logic [VEC_W-1:0]  VMAX = {AXES{CMAX}};
	localparam logic [VEC_W-1:0]  VMIN = {AXES{CMIN}};

	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic             func;
		logic [VEC_W-1:0] normal;
		logic [VEC_W-1:0] frc;
		logic [VEC_W-1:0] pos;
		logic [VEC_W-1:0] tpos;
		logic [VEC_W-1:0] tvel;
	} step_t;

	typedef struct packed {
		logic [CMD_W-1:0] x;
		logic [CMD_W-1:0] y;
		logic [CMD_W-1:0] z;
		logic             clipped;
	} cmd_t;

	typedef logic [4:0][CFG_DATA_W-1:0] cfg_set_t;

	typedef struct {
		bit       is_cfg;
		cfg_set_t regs;
		step_t    stim;
		bit       known;
		cmd_t     want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stfvc_in_if  step_ch();
	stfvc_out_if cmd_ch();

	surface_tracing_force_velocity_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (step_ch),
		.result    (cmd_ch)
	);

	longint set_pt;
	longint p_gain;
	longint i_gain;
	longint t_gain;
	longint period;
	longint force_integral;
	bit     clip_seen;

	cmd_t cmd_due[$];
	int   mismatch_count = 0;
	int   hold_reqs = 0;
	int   burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("surface_tracing_force_velocity_control regression: fail");
		$finish;
	end

	function automatic longint comp(logic [VEC_W-1:0] v, int k);
		logic signed [COMP_W-1:0] c;
		c = v[k*COMP_W +: COMP_W];
		return c;
	endfunction

	function automatic longint clamp(longint x, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (x < lo) begin
			clip_seen = 1'b1;
			return lo;
		end
		return x;
	endfunction

	function automatic cmd_t predict_cmd(step_t s);
		longint n[AXES];
		longint v[AXES];
		longint fn;
		longint err;
		longint vf;
		longint nv;
		longint w;
		longint dp;
		cmd_t   c;
		int     k;
		clip_seen = 1'b0;
		fn = 0;
		nv = 0;
		if (s.func == OP_CLEAR) begin
			force_integral = 0;
			return '0;
		end
		for (k = 0; k < AXES; k++) begin
			n[k] = comp(s.normal, k);
			fn += n[k] * comp(s.frc, k);
		end
		err = (fn - set_pt * 262144) >>> 10;
		force_integral = clamp(force_integral + ((err * period) >>> 16), INTEG_W);
		vf = clamp((((force_integral >>> 8) * i_gain) >>> 16) + ((err * p_gain) >>> 16),
			VEL_W);
		for (k = 0; k < AXES; k++) begin
			dp = comp(s.pos, k) - comp(s.tpos, k);
			v[k] = clamp(comp(s.tvel, k) - ((dp * t_gain) >>> 16), VEL_W);
			nv += n[k] * v[k];
		end
		w = vf - (nv >>> 18);
		c.x = clamp(v[0] + ((n[0] * w) >>> 18), CMD_W);
		c.y = clamp(v[1] + ((n[1] * w) >>> 18), CMD_W);
		c.z = clamp(v[2] + ((n[2] * w) >>> 18), CMD_W);
		c.clipped = clip_seen;
		return c;
	endfunction

	function automatic logic [VEC_W-1:0] vec3(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
		logic [COMP_W-1:0] z);
		return {z, y, x};
	endfunction

	function automatic step_t mkstep(logic f, logic [VEC_W-1:0] n, logic [VEC_W-1:0] fr,
		logic [VEC_W-1:0] p, logic [VEC_W-1:0] tp, logic [VEC_W-1:0] tv);
		step_t s;
		s.func = f;
		s.normal = n;
		s.frc = fr;
		s.pos = p;
		s.tpos = tp;
		s.tvel = tv;
		return s;
	endfunction

	function automatic cmd_t cmd_word(logic [CMD_W-1:0] x, logic [CMD_W-1:0] y,
		logic [CMD_W-1:0] z, logic c);
		cmd_t w;
		w.x = x;
		w.y = y;
		w.z = z;
		w.clipped = c;
		return w;
	endfunction

	function automatic cfg_set_t mk_cfg(logic [CFG_DATA_W-1:0] sp, logic [CFG_DATA_W-1:0] pg,
		logic [CFG_DATA_W-1:0] ig, logic [CFG_DATA_W-1:0] tg, logic [CFG_DATA_W-1:0] per);
		cfg_set_t r;
		r = '0;
		r[CFG_FORCE_SETPOINT] = sp;
		r[CFG_PROP_GAIN] = pg;
		r[CFG_INTEG_GAIN] = ig;
		r[CFG_TRAJ_GAIN] = tg;
		r[CFG_SAMPLE_PERIOD] = per;
		return r;
	endfunction

	function automatic row_t cfg_row(cfg_set_t r);
		row_t row;
		row.is_cfg = 1'b1;
		row.regs = r;
		row.stim = '0;
		row.known = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic row_t step_row(step_t s);
		row_t row;
		row.is_cfg = 1'b0;
		row.regs = '0;
		row.stim = s;
		row.known = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic row_t known_row(step_t s, cmd_t w);
		row_t row;
		row = step_row(s);
		row.known = 1'b1;
		row.want = w;
		return row;
	endfunction

	function automatic logic [VEC_W-1:0] rnd60();
		logic [63:0] t;
		t = {$urandom(), $urandom()};
		return t[VEC_W-1:0];
	endfunction

	function automatic logic [COMP_W-1:0] rc(int mag);
		int t;
		t = int'($urandom_range(0, 2 * mag)) - mag;
		return t[COMP_W-1:0];
	endfunction

	function automatic step_t rand_step();
		step_t                s;
		int                   ax;
		logic [COMP_W-1:0]    u;
		logic [COMP_W-1:0]    d;
		s.func = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_STEP;
		ax = $urandom_range(0, AXES - 1);
		s.normal = '0;
		case ($urandom_range(0, 4))
			0, 1: begin
				u = UNIT;
				if ($urandom_range(0, 1)) u = -u;
				s.normal[ax*COMP_W +: COMP_W] = u;
			end
			2: begin
				u = DIAG;
				d = DIAG;
				if ($urandom_range(0, 1)) u = -u;
				if ($urandom_range(0, 1)) d = -d;
				s.normal[((ax + 1) % AXES)*COMP_W +: COMP_W] = u;
				s.normal[((ax + 2) % AXES)*COMP_W +: COMP_W] = d;
			end
			default: s.normal = rnd60();
		endcase
		s.frc = $urandom_range(0, 1) ? vec3(rc(5120), rc(5120), rc(5120)) : rnd60();
		s.pos = rnd60();
		if ($urandom_range(0, 2) != 0) begin
			s.tpos = vec3(s.pos[19:0] + rc(4096), s.pos[39:20] + rc(4096),
				s.pos[59:40] + rc(4096));
		end else begin
			s.tpos = rnd60();
		end
		s.tvel = $urandom_range(0, 1) ? vec3(rc(65536), rc(65536), rc(65536)) : rnd60();
		return s;
	endfunction

	function automatic void check_cmd();
		cmd_t got;
		cmd_t want;
		got = {cmd_ch.cmd_x, cmd_ch.cmd_y, cmd_ch.cmd_z, cmd_ch.clipped};
		if (cmd_due.size() == 0) begin
			$error("command word with nothing expected: x=%0d y=%0d z=%0d clipped=%0b",
				$signed(got.x), $signed(got.y), $signed(got.z), got.clipped);
			mismatch_count++;
			return;
		end
		want = cmd_due.pop_front();
		if (got.x !== want.x) begin
			$error("cmd_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
			mismatch_count++;
		end
		if (got.y !== want.y) begin
			$error("cmd_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
			mismatch_count++;
		end
		if (got.z !== want.z) begin
			$error("cmd_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
			mismatch_count++;
		end
		if (got.clipped !== want.clipped) begin
			$error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
			mismatch_count++;
		end
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic cfg_apply(cfg_set_t r);
		logic signed [SP_W-1:0] sp;
		write_reg(CFG_FORCE_SETPOINT, r[CFG_FORCE_SETPOINT]);
		write_reg(CFG_PROP_GAIN, r[CFG_PROP_GAIN]);
		write_reg(CFG_INTEG_GAIN, r[CFG_INTEG_GAIN]);
		write_reg(CFG_TRAJ_GAIN, r[CFG_TRAJ_GAIN]);
		write_reg(CFG_SAMPLE_PERIOD, r[CFG_SAMPLE_PERIOD]);
		cfg_we <= 1'b0;
		sp = r[CFG_FORCE_SETPOINT][SP_W-1:0];
		set_pt = sp;
		p_gain = r[CFG_PROP_GAIN];
		i_gain = r[CFG_INTEG_GAIN];
		t_gain = r[CFG_TRAJ_GAIN];
		period = r[CFG_SAMPLE_PERIOD];
	endtask

	// hold the word until taken, then queue its command word
	task automatic issue(step_t s, bit known = 1'b0, cmd_t want = '0);
		cmd_t p;
		if (burst_left == 0) begin
			step_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 20);
		end
		burst_left--;
		step_ch.valid <= 1'b1;
		step_ch.func <= s.func;
		step_ch.normal_vec <= s.normal;
		step_ch.force_vec <= s.frc;
		step_ch.position <= s.pos;
		step_ch.target_position <= s.tpos;
		step_ch.target_velocity <= s.tvel;
		do @(posedge clk); while (!(step_ch.valid && step_ch.ready));
		p = predict_cmd(s);
		cmd_due.push_back(known ? want : p);
	endtask

	task automatic drain();
		step_ch.valid <= 1'b0;
		while (cmd_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(cfg_set_t r, int count, int wdir);
		step_t s;
		int    i;
		int    k;
		bit    sgn;
		int    nm;
		int    fm;
		drain();
		cfg_apply(r);
		for (i = 0; i < count; i++) begin
			s = rand_step();
			if (wdir != 0) begin
				s.func = OP_STEP;
				for (k = 0; k < AXES; k++) begin
					sgn = $urandom_range(0, 1);
					nm = $urandom_range(480000, 524287);
					fm = $urandom_range(480000, 524287);
					s.normal[k*COMP_W +: COMP_W] = sgn ? -nm : nm;
					s.frc[k*COMP_W +: COMP_W] = (sgn ^ (wdir < 0)) ? -fm : fm;
				end
			end
			issue(s);
		end
	endtask

	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int holds_done;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		holds_done = 0;
		cmd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (cmd_ch.valid && cmd_ch.ready) check_cmd();
			if (hold_left == 0 && holds_done < hold_reqs) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				cmd_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: cmd_ch.ready <= 1'b1;
					1: cmd_ch.ready <= $urandom_range(0, 1);
					2: cmd_ch.ready <= ($urandom_range(0, 3) == 0);
					default: cmd_ch.ready <= (mode_left % 7 != 0);
				endcase
			end
		end
	end

	initial begin
		row_t plan[$];
		int   wdir;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FORCE_SETPOINT;
		cfg_data <= '0;
		step_ch.valid <= 1'b0;
		step_ch.func <= OP_STEP;
		step_ch.normal_vec <= '0;
		step_ch.force_vec <= '0;
		step_ch.position <= '0;
		step_ch.target_position <= '0;
		step_ch.target_velocity <= '0;
		set_pt = 0;
		p_gain = 0;
		i_gain = 0;
		t_gain = 0;
		period = SAMPLE_PERIOD_RST;
		force_integral = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(known_row(mkstep(OP_STEP, '0, VMAX, VMAX, VMIN,
			vec3(20'd1, 20'hFFFFF, CMAX)), cmd_word(24'd1, 24'hFFFFFF, 24'd524287, 1'b0)));
		plan.push_back(known_row(mkstep(OP_STEP, '0, VMIN, VMIN, VMAX, VMIN),
			cmd_word(24'hF80000, 24'hF80000, 24'hF80000, 1'b0)));
		plan.push_back(known_row(mkstep(OP_CLEAR, '1, '1, '1, '1, '1),
			cmd_word(24'd0, 24'd0, 24'd0, 1'b0)));
		plan.push_back(known_row(mkstep(OP_STEP, vec3(20'd0, 20'd0, UNIT),
			vec3(20'd0, 20'd0, 20'd2560), vec3(20'd1000, 20'd0, 20'd0), '0,
			vec3(20'd65536, 20'hF0000, 20'd131072)),
			cmd_word(24'd65536, 24'hFF0000, 24'd0, 1'b0)));
		plan.push_back(step_row(mkstep(OP_STEP, '1, '1, '1, '1, '1)));
		plan.push_back(step_row(mkstep(OP_STEP, VMAX, VMAX, VMAX, VMAX, VMAX)));
		plan.push_back(step_row(mkstep(OP_STEP, VMIN, VMIN, VMIN, VMIN, VMIN)));
		plan.push_back(step_row(mkstep(OP_STEP, VMAX, VMIN, VMAX, VMIN, VMAX)));
		plan.push_back(cfg_row(mk_cfg(24'd5120, 24'd65536, 24'd32768, 24'd131072,
			SAMPLE_PERIOD_RST)));
		plan.push_back(step_row(mkstep(OP_STEP, vec3(20'd0, 20'd0, UNIT),
			vec3(20'd0, 20'd0, 20'd3840), vec3(20'd1000, -20'd2000, 20'd500),
			vec3(20'd900, -20'd1800, 20'd700), vec3(20'd32768, 20'd16384, 20'd4096))));
		plan.push_back(step_row(mkstep(OP_STEP, vec3(DIAG, 20'd0, DIAG),
			vec3(20'd5000, 20'd100, 20'd5000), vec3(20'd100, 20'd200, 20'd300),
			'0, vec3(20'd32768, -20'd32768, 20'd8192))));
		plan.push_back(step_row(mkstep(OP_STEP, VMAX, vec3(20'd256, 20'd256, 20'd256),
			'0, '0, vec3(20'd65536, 20'd0, -20'd65536))));
		plan.push_back(known_row(mkstep(OP_CLEAR, VMAX, VMAX, VMAX, VMIN, VMAX),
			cmd_word(24'd0, 24'd0, 24'd0, 1'b0)));
		plan.push_back(cfg_row(mk_cfg(24'h080000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'd0)));
		plan.push_back(step_row(mkstep(OP_STEP, vec3(UNIT, 20'd0, 20'd0),
			vec3(CMAX, 20'd0, 20'd0), '0, '0, '0)));
		plan.push_back(step_row(mkstep(OP_STEP, '0, '0, VMAX, VMIN, VMAX)));
		plan.push_back(step_row(mkstep(OP_STEP, VMIN, VMIN, VMIN, VMAX, VMIN)));
		plan.push_back(cfg_row(mk_cfg(24'h07FFFF, 24'd0, 24'd0, 24'd0, 24'hFFFFFF)));
		plan.push_back(step_row(mkstep(OP_STEP, vec3(20'd0, 20'd0, -UNIT),
			vec3(20'd0, 20'd0, CMIN), '0, '0, vec3(20'd65536, 20'd65536, 20'd65536))));
		plan.push_back(step_row(rand_step()));
		plan.push_back(known_row(mkstep(OP_CLEAR, '0, '0, '0, '0, '0),
			cmd_word(24'd0, 24'd0, 24'd0, 1'b0)));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				cfg_apply(plan[i].regs);
			end else begin
				issue(plan[i].stim, plan[i].known, plan[i].want);
			end
		end

		run_phase(mk_cfg(rc(12800), $urandom_range(0, 24'h40000), $urandom_range(0, 24'h40000),
			$urandom_range(0, 24'h20000), 24'd1), 60, 0);
		run_phase(mk_cfg(24'h080000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 60, 0);
		run_phase(mk_cfg(24'd0, 24'd0, 24'd0, 24'd0, 24'd0), 40, 0);
		hold_reqs++;
		run_phase(mk_cfg($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF)), 60, 0);
		wdir = $urandom_range(0, 1) ? 1 : -1;
		hold_reqs++;
		run_phase(mk_cfg((wdir > 0) ? 24'h080000 : 24'h07FFFF, $urandom_range(0, 24'hFFFF),
			$urandom_range(0, 24'hFFFF), $urandom_range(0, 24'h20000), 24'hFFFFFF), 700, wdir);
		run_phase(mk_cfg(rc(12800), $urandom_range(0, 24'h40000), $urandom_range(0, 24'h40000),
			$urandom_range(0, 24'h40000), $urandom_range(1, 24'hFFFFFF)), 80, 0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cmd_due.size() == 0) begin
			$display("surface_tracing_force_velocity_control regression: pass");
		end else begin
			$display("surface_tracing_force_velocity_control regression: fail");
		end
		$finish;
	end

endmodule
